// ===== rtl/cbr_pkg.sv =====
// Shared types and constants for the circular bit reservoir reader.
package cbr_pkg;

    localparam int STORE_BYTES   = 4096;
    localparam int MAX_READ_BITS = 32;

    localparam int ADDR_W  = $clog2(STORE_BYTES);
    localparam int CNT_W   = $clog2(MAX_READ_BITS + 1);
    localparam int TOT_W   = CNT_W + 1;
    localparam int LEFT_W  = $clog2(MAX_READ_BITS / 8 + 2);
    localparam int ACC_W   = MAX_READ_BITS + 8;
    localparam int POS_W   = 35;
    localparam int WCNT_W  = 32;

    localparam logic [1:0] CMD_PUT       = 2'd0;
    localparam logic [1:0] CMD_READ      = 2'd1;
    localparam logic [1:0] CMD_REW_BITS  = 2'd2;
    localparam logic [1:0] CMD_REW_BYTES = 2'd3;

    localparam logic [1:0] ST_OK           = 2'd0;
    localparam logic [1:0] ST_PAST_DATA    = 2'd1;
    localparam logic [1:0] ST_BEFORE_START = 2'd2;
    localparam logic [1:0] ST_BAD_COUNT    = 2'd3;

    localparam logic [14:0] PUT_WIDTH = 15'd8;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  byte_value;
        logic [14:0] count;
    } t_in_item;

    typedef struct packed {
        logic [31:0] read_value;
        logic [31:0] bit_position;
        logic [1:0]  status;
    } t_out_item;

    // control from the sequencer to the byte gatherer
    typedef struct packed {
        logic             clear;
        logic             shift;
        logic [2:0]       drop;
        logic [CNT_W-1:0] nbits;
    } t_acc_ctl;

endpackage

// ===== rtl/cbr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module cbr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/cbr_gather.sv =====
// Byte-serial gatherer: shifts fetched bytes in MSB first, then aligns and masks the field.
module cbr_gather (
    input  logic            i_clk,
    input  cbr_pkg::t_acc_ctl i_ctl,
    input  logic [7:0]      i_byte,
    output logic [31:0]     o_value
);
    import cbr_pkg::*;

    logic [ACC_W-1:0]         r_acc;
    logic [ACC_W-1:0]         n_acc;
    logic [ACC_W-1:0]         aligned;
    logic [MAX_READ_BITS-1:0] ones;
    logic [MAX_READ_BITS-1:0] mask;
    logic [MAX_READ_BITS-1:0] field;

    always_comb begin
        n_acc = r_acc;
        if (i_ctl.clear) begin
            n_acc = '0;
        end else if (i_ctl.shift) begin
            n_acc = {r_acc[ACC_W-9:0], i_byte};
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    // trailing bits past the field are at most 7; leading skipped bits fall to the mask
    assign aligned = r_acc >> i_ctl.drop;
    assign ones    = '1;
    assign mask    = ~(ones << i_ctl.nbits);
    assign field   = aligned[MAX_READ_BITS-1:0] & mask;
    assign o_value = field[31:0];

endmodule

// ===== rtl/circular_bit_reservoir_reader_unit.sv =====
// Top level: command sequencer, byte store and result register of the bit reservoir reader.
// Commands are taken one at a time. A put, a rewind or a read with a bad count
// passes through S_EXEC and S_DONE; a read past the written data passes through
// S_EXEC, S_CHECK and S_DONE; an accepted read passes through S_EXEC, S_CHECK,
// S_FETCH once for each of the n (1 to 5) stored bytes the requested bits touch,
// S_WAIT and S_DONE, because the byte store has one read port and delivers one
// byte per cycle. S_DONE holds while the output register is full and not taken; the
// input is ready again in the cycle after the result is placed.
// A new command is accepted as soon as the previous one has placed its result in
// the output register, even if that result has not been taken.
module circular_bit_reservoir_reader_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  cbr_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output cbr_pkg::t_out_item o_out_data
);
    import cbr_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_FETCH = 3'd3;
    localparam logic [2:0] S_WAIT  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]        r_state, n_state;
    logic [1:0]        r_cmd;
    logic [7:0]        r_byte;
    logic [14:0]       r_cnt;
    logic [1:0]        r_status, n_status;
    logic [WCNT_W-1:0] r_bw, n_bw;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [POS_W:0]    r_last, n_last;
    logic [TOT_W-1:0]  r_tot, n_tot;
    logic [LEFT_W-1:0] r_left, n_left;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic              r_rd_pend;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out, n_out;

    logic              ram_we, ram_re;
    logic [7:0]        ram_q;
    t_acc_ctl          acc_ctl;
    logic              acc_clear;
    logic [31:0]       gathered;
    logic [17:0]       back;
    logic [POS_W:0]    diff;
    logic [POS_W-1:0]  pos_adv;
    logic              out_free;
    logic              read_ok;

    assign o_in_ready = (r_state == S_IDLE);
    assign out_free   = !r_out_valid || i_out_ready;
    assign back       = (r_cmd == CMD_REW_BITS) ? {3'd0, r_cnt} : {r_cnt, 3'd0};
    assign diff       = {1'b0, r_pos} - (POS_W+1)'(back);
    assign pos_adv    = r_pos + POS_W'(r_cnt[CNT_W-1:0]);
    assign read_ok    = (r_cmd == CMD_READ) && (r_status == ST_OK);

    always_comb begin
        n_state     = r_state;
        n_status    = r_status;
        n_bw        = r_bw;
        n_pos       = r_pos;
        n_last      = r_last;
        n_tot       = r_tot;
        n_left      = r_left;
        n_addr      = r_addr;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        acc_clear   = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state  = S_EXEC;
                    n_status = ST_OK;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
                case (r_cmd)
                    CMD_PUT: begin
                        if (r_cnt != PUT_WIDTH) begin
                            n_status = ST_BAD_COUNT;
                        end else begin
                            ram_we = 1'b1;
                            n_bw   = r_bw + 1'b1;
                        end
                    end
                    CMD_READ: begin
                        if (r_cnt == '0 || r_cnt > 15'(MAX_READ_BITS)) begin
                            n_status = ST_BAD_COUNT;
                        end else begin
                            n_last    = {1'b0, r_pos} + (POS_W+1)'(r_cnt) - 1'b1;
                            n_tot     = TOT_W'(r_pos[2:0]) + TOT_W'(r_cnt[CNT_W-1:0]);
                            n_addr    = r_pos[ADDR_W+2:3];
                            acc_clear = 1'b1;
                            n_state   = S_CHECK;
                        end
                    end
                    default: begin
                        if (diff[POS_W]) begin
                            n_status = ST_BEFORE_START;
                        end else begin
                            n_pos = diff[POS_W-1:0];
                        end
                    end
                endcase
            end
            S_CHECK: begin
                // last byte touched must already be written
                if (r_last[POS_W:3] >= {1'b0, r_bw}) begin
                    n_status = ST_PAST_DATA;
                    n_state  = S_DONE;
                end else begin
                    n_left  = LEFT_W'((r_tot + TOT_W'(7)) >> 3);
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                ram_re = 1'b1;
                n_addr = r_addr + 1'b1;
                n_left = r_left - 1'b1;
                if (r_left == LEFT_W'(1)) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out.status = r_status;
                    if (read_ok) begin
                        n_pos              = pos_adv;
                        n_out.read_value   = gathered;
                        n_out.bit_position = pos_adv[31:0];
                    end else begin
                        n_out.read_value   = '0;
                        n_out.bit_position = r_pos[31:0];
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bw        <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
            r_rd_pend   <= 1'b0;
            r_status    <= ST_OK;
        end else begin
            r_state     <= n_state;
            r_bw        <= n_bw;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
            r_rd_pend   <= ram_re;
            r_status    <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_cmd  <= i_in_data.command;
            r_byte <= i_in_data.byte_value;
            r_cnt  <= i_in_data.count;
        end
        r_last <= n_last;
        r_tot  <= n_tot;
        r_left <= n_left;
        r_addr <= n_addr;
        r_out  <= n_out;
    end

    assign acc_ctl = '{
        clear: acc_clear,
        shift: r_rd_pend,
        drop:  3'd0 - r_tot[2:0],
        nbits: r_cnt[CNT_W-1:0]
    };

    cbr_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_bw[ADDR_W-1:0]),
        .i_wdata (r_byte),
        .i_re    (ram_re),
        .i_raddr (r_addr),
        .o_rdata (ram_q)
    );

    cbr_gather u_gather (
        .i_clk   (i_clk),
        .i_ctl   (acc_ctl),
        .i_byte  (ram_q),
        .o_value (gathered)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== tb/circular_bit_reservoir_reader_unit_tb.sv =====
// Self-checking testbench for the circular bit reservoir reader: directed, random and backpressure tests.
module circular_bit_reservoir_reader_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cbr_pkg::*;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_data;

    circular_bit_reservoir_reader_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // shadow copy of the reservoir
    logic [7:0]        resv_mem [STORE_BYTES];
    logic [WCNT_W-1:0] bytes_put = '0;
    logic [POS_W-1:0]  consumed_bits = '0;

    t_out_item pending_results[$];
    int        err_count = 0;
    int        src_gap_pct = 0;
    int        sink_stall_pct = 0;
    int        sink_hold = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("circular_bit_reservoir_reader_unit: mismatch");
        $finish;
    end

    // Applies one command to the shadow state and returns the result it should give.
    function automatic t_out_item predict_result(t_in_item cmd);
        t_out_item        res;
        logic [POS_W-1:0] back;
        logic [POS_W-1:0] p;
        logic [POS_W-1:0] last_byte;
        logic [63:0]      acc;
        logic [7:0]       b;
        res = '0;
        acc = '0;
        res.status = ST_OK;
        case (cmd.command)
            CMD_PUT: begin
                if (cmd.count != PUT_WIDTH) begin
                    res.status = ST_BAD_COUNT;
                end else begin
                    resv_mem[bytes_put % STORE_BYTES] = cmd.byte_value;
                    bytes_put = bytes_put + 1'b1;
                end
            end
            CMD_READ: begin
                if (cmd.count == 0 || cmd.count > MAX_READ_BITS) begin
                    res.status = ST_BAD_COUNT;
                end else begin
                    last_byte = (consumed_bits + cmd.count - 1'b1) >> 3;
                    if (last_byte >= bytes_put) begin
                        res.status = ST_PAST_DATA;
                    end else begin
                        p = consumed_bits;
                        for (int i = 0; i < cmd.count; i++) begin
                            b = resv_mem[(p >> 3) % STORE_BYTES];
                            acc = {acc[62:0], b[7 - p[2:0]]};
                            p = p + 1'b1;
                        end
                        consumed_bits = p;
                    end
                end
            end
            default: begin
                back = {20'd0, cmd.count};
                if (cmd.command == CMD_REW_BYTES) back = back << 3;
                if (back > consumed_bits) res.status = ST_BEFORE_START;
                else consumed_bits = consumed_bits - back;
            end
        endcase
        res.read_value   = acc[31:0];
        res.bit_position = consumed_bits[31:0];
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (err_count < 100)
            $display("ERROR %0t: %s got %0h expected %0h", $realtime, what, got, want);
        err_count++;
    endtask

    // check first, then record, so a result never meets the prediction of the same edge
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result, status", 32'(o_out_data.status), '0);
            end else begin
                want = pending_results.pop_front();
                if (o_out_data.read_value !== want.read_value)
                    report_mismatch("read_value", o_out_data.read_value, want.read_value);
                if (o_out_data.bit_position !== want.bit_position)
                    report_mismatch("bit_position", o_out_data.bit_position, want.bit_position);
                if (o_out_data.status !== want.status)
                    report_mismatch("status", 32'(o_out_data.status), 32'(want.status));
            end
        end
        if (i_rst_n && i_in_valid && o_in_ready)
            pending_results.push_back(predict_result(i_in_data));
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap_len();
        int r;
        r = $urandom_range(99);
        if (r < 80) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // result side: forced hold-off first, then random stalls
    initial begin
        int stall_left;
        stall_left = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (sink_hold > 0) begin
                i_out_ready <= 1'b0;
                sink_hold--;
            end else if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else if ($urandom_range(99) < sink_stall_pct) begin
                i_out_ready <= 1'b0;
                stall_left = pick_gap_len() - 1;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    task automatic send_cmd(logic [1:0] c, logic [7:0] v, logic [14:0] n);
        int gap;
        gap = ($urandom_range(99) < src_gap_pct) ? pick_gap_len() : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= '{command: c, byte_value: v, count: n};
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // mostly well-formed traffic that keeps the reader close behind the writer
    task automatic send_random_cmd();
        int     r;
        longint avail;
        longint pos_now;
        longint lim;
        logic [14:0] n;
        r = $urandom_range(99);
        pos_now = longint'(consumed_bits);
        avail = longint'({bytes_put, 3'b000}) - pos_now;
        if (r < 8) begin
            case ($urandom_range(3))
                0: begin
                    n = 15'($urandom_range(32767));
                    if (n == PUT_WIDTH) n = 15'd9;
                    send_cmd(CMD_PUT, 8'($urandom), n);
                end
                1: begin
                    if (avail < MAX_READ_BITS)
                        n = 15'($urandom_range(MAX_READ_BITS, int'(avail) + 1));
                    else if ($urandom_range(1) == 0)
                        n = '0;
                    else
                        n = 15'($urandom_range(32767, MAX_READ_BITS + 1));
                    send_cmd(CMD_READ, 8'($urandom), n);
                end
                2: send_cmd(CMD_REW_BITS, 8'($urandom), 15'($urandom_range(32767)));
                default: send_cmd(CMD_REW_BYTES, 8'($urandom), 15'($urandom_range(32767)));
            endcase
        end else if (r < 45 || avail == 0) begin
            send_cmd(CMD_PUT, 8'($urandom), PUT_WIDTH);
        end else if (r < 85) begin
            lim = (avail > MAX_READ_BITS) ? MAX_READ_BITS : avail;
            send_cmd(CMD_READ, 8'($urandom), 15'($urandom_range(1, int'(lim))));
        end else if (r < 93) begin
            lim = (pos_now > 64) ? 64 : pos_now;
            send_cmd(CMD_REW_BITS, 8'($urandom), 15'($urandom_range(0, int'(lim))));
        end else begin
            lim = ((pos_now >> 3) > 8) ? 8 : (pos_now >> 3);
            send_cmd(CMD_REW_BYTES, 8'($urandom), 15'($urandom_range(0, int'(lim))));
        end
    endtask

    task automatic test_directed();
        src_gap_pct = 20;
        sink_stall_pct = 20;
        send_cmd(CMD_READ, 8'h00, 15'd8);           // nothing written yet
        send_cmd(CMD_REW_BITS, 8'h00, 15'd1);       // before start
        send_cmd(CMD_REW_BITS, 8'hff, 15'd0);
        send_cmd(CMD_REW_BYTES, 8'hff, 15'd0);
        send_cmd(CMD_PUT, 8'h12, 15'd0);            // bad put widths
        send_cmd(CMD_PUT, 8'hff, 15'h7fff);
        send_cmd(CMD_PUT, 8'hff, PUT_WIDTH);
        send_cmd(CMD_PUT, 8'h00, PUT_WIDTH);
        send_cmd(CMD_PUT, 8'ha5, PUT_WIDTH);
        send_cmd(CMD_PUT, 8'h5a, PUT_WIDTH);
        send_cmd(CMD_PUT, 8'h81, PUT_WIDTH);
        send_cmd(CMD_READ, 8'h00, 15'd0);           // bad read counts
        send_cmd(CMD_READ, 8'h00, 15'(MAX_READ_BITS + 1));
        send_cmd(CMD_READ, 8'h00, 15'h7fff);
        send_cmd(CMD_READ, 8'h00, 15'd1);
        send_cmd(CMD_READ, 8'h00, 15'(MAX_READ_BITS));
        send_cmd(CMD_READ, 8'h00, 15'd8);           // runs one byte past the data
        send_cmd(CMD_REW_BYTES, 8'h00, 15'd5);      // too far back
        send_cmd(CMD_REW_BYTES, 8'h00, 15'd4);
        send_cmd(CMD_REW_BITS, 8'h00, 15'd1);
        send_cmd(CMD_READ, 8'h00, 15'(MAX_READ_BITS));
        send_cmd(CMD_READ, 8'h00, 15'd8);           // ends exactly on the last byte
        send_cmd(CMD_READ, 8'h00, 15'd1);
        send_cmd(CMD_PUT, 8'h3c, 15'h4000);
        send_cmd(CMD_REW_BYTES, 8'h00, 15'h4000);
        wait_drained();
    endtask

    task automatic test_random();
        for (int blk = 0; blk < 9; blk++) begin
            case ($urandom_range(3))
                0: src_gap_pct = 0;
                1: src_gap_pct = 10;
                2: src_gap_pct = 30;
                default: src_gap_pct = 60;
            endcase
            case ($urandom_range(3))
                0: sink_stall_pct = 0;
                1: sink_stall_pct = 10;
                2: sink_stall_pct = 30;
                default: sink_stall_pct = 60;
            endcase
            repeat (100) send_random_cmd();
            if ($urandom_range(1) == 0) wait_drained();
        end
        wait_drained();
    endtask

    // receiver stops long enough for the block to fill and stall its input
    task automatic test_backpressure();
        src_gap_pct = 0;
        sink_stall_pct = 0;
        @(posedge i_clk);
        sink_hold = 300;
        repeat (40) send_random_cmd();
        wait_drained();
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random();
        test_backpressure();
        wait_drained();
        repeat (40) @(posedge i_clk);
        if (err_count == 0) begin
            $display("circular_bit_reservoir_reader_unit: match");
        end else begin
            $display("circular_bit_reservoir_reader_unit: mismatch");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/cbr_pkg.sv
rtl/cbr_ram.sv
rtl/cbr_gather.sv
rtl/circular_bit_reservoir_reader_unit.sv
tb/circular_bit_reservoir_reader_unit_tb.sv
